FILE: sv/qbt_pkg.sv
// ---------------------------------------------------------------------------
// qbt_pkg
// shared types, codes and helpers for the quintic bezier trajectory block
// ---------------------------------------------------------------------------
package qbt_pkg;

  // working width of the horner accumulator and coefficient storage
  localparam int ACC_W  = 48;
  localparam int COEF_W = 40;
  localparam int DUR_W  = 16;

  // item function codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_EVAL  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_POINT0   = 3'd0;
  localparam logic [2:0] REG_POINT1   = 3'd1;
  localparam logic [2:0] REG_POINT2   = 3'd2;
  localparam logic [2:0] REG_POINT3   = 3'd3;
  localparam logic [2:0] REG_POINT4   = 3'd4;
  localparam logic [2:0] REG_POINT5   = 3'd5;
  localparam logic [2:0] REG_DURATION = 3'd6;

  localparam logic [DUR_W-1:0] DUR_RESET = 16'd1000;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } qbt_div_stat_t;

  // clamp an accumulator value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    lo = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    if (v > hi) begin
      sat32 = 32'h7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: sv/qbt_div.sv
// ---------------------------------------------------------------------------
// qbt_div
// restoring unsigned divider, one quotient bit per cycle, 16-bit divisor
// ---------------------------------------------------------------------------
module qbt_div #(
  parameter int DIV_W = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIV_W-1:0]         dividend,
  input  logic [qbt_pkg::DUR_W-1:0] divisor,
  output qbt_pkg::qbt_div_stat_t   stat,
  output logic [DIV_W-1:0]         quotient
);
  import qbt_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DUR_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DUR_W:0]   trial;
  logic             ge;

  // shift in next dividend bit and trial subtract
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DUR_W'(trial - {1'b0, divisor}) : trial[DUR_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

FILE: sv/quintic_bezier_trajectory.sv
// ---------------------------------------------------------------------------
// quintic_bezier_trajectory
// quintic bezier motion profile: tick timer, position, velocity, acceleration
// ---------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | slave     | tvalid / tready  | tdata: func, tuser: backward
//  out_    | master    | tvalid / tready  | tdata: pos, vel, acc, tuser: finished
//  cfg_    | apb slave | psel / penable   | points 0..5, duration_ticks
//
//  tick, start and spare words pass through S_FIN, which loads the result
//  into the output register once that register is free or draining.
//  an evaluate word runs the time divide (skipped once the run has finished),
//  the horner steps and the velocity divide before the next accept; the pace
//  is set by the shared bit-serial divider and the shared
//  shift-add multiplier running the horner steps.
//  in_tready is high only while the sequencer is idle; a result waits in the
//  output register while the next word is accepted.
//  synchronous active-low reset; coefficients are registered from the point registers.
// ---------------------------------------------------------------------------
module quintic_bezier_trajectory #(
  parameter int TIME_BITS   = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [1:0] func
  input  logic        in_tuser,    // [0] backward
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // [31:0] position, [63:32] velocity, [95:64] acceleration
  output logic        out_tuser,   // [0] finished
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import qbt_pkg::*;

  localparam int EL_W  = (TIME_BITS + 1 > DUR_W + 1) ? TIME_BITS + 1 : DUR_W + 1;
  localparam int T_W   = T_FRAC_BITS + 1;
  localparam int PW    = ACC_W + T_W;
  localparam int DIV_W = (ACC_W > EL_W + T_FRAC_BITS) ? ACC_W : EL_W + T_FRAC_BITS;
  localparam int MC_W  = $clog2(T_W + 1);
  localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_TDIV, S_LOAD, S_MUL, S_ADD, S_VDIV, S_FIN
  } state_t;

  state_t                   st_r;
  logic signed [31:0]       point_r [6];
  logic [DUR_W-1:0]         dur_r;
  logic [EL_W-1:0]          elapsed_r;
  logic signed [COEF_W-1:0] coef_r [6];
  logic [T_W-1:0]           t_r;
  logic                     back_r;
  logic [3:0]               m_r;
  logic signed [ACC_W-1:0]  h_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [PW-1:0]     mcand_r;
  logic [T_W-1:0]           tsh_r;
  logic [MC_W-1:0]          mcnt_r;
  logic signed [ACC_W-1:0]  pos_r;
  logic signed [ACC_W-1:0]  vel_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     vneg_r;
  logic                     out_valid_r;
  logic [95:0]              out_data_r;
  logic                     out_fin_r;

  logic [DUR_W-1:0]         dur_eff;
  logic                     cfg_wr;
  logic [2:0]               cfg_idx;
  logic                     in_acc;
  logic                     finished;
  logic signed [ACC_W-1:0]  b [6];
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  horner;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DIV_W-1:0]         div_quo;
  qbt_div_stat_t            div_stat;
  logic [T_W-1:0]           t_div;
  logic signed [ACC_W-1:0]  d_fin;

  assign dur_eff  = (dur_r == '0) ? DUR_W'(1) : dur_r;
  assign cfg_wr   = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx  = cfg_paddr[4:2];
  assign in_acc   = in_tvalid & in_tready;
  assign finished = elapsed_r > EL_W'(dur_eff);
  assign cfg_pready = 1'b1;
  assign in_tready  = (st_r == S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) point_r[i] <= '0;
      dur_r <= DUR_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_POINT0:   point_r[0] <= cfg_pwdata;
        REG_POINT1:   point_r[1] <= cfg_pwdata;
        REG_POINT2:   point_r[2] <= cfg_pwdata;
        REG_POINT3:   point_r[3] <= cfg_pwdata;
        REG_POINT4:   point_r[4] <= cfg_pwdata;
        REG_POINT5:   point_r[5] <= cfg_pwdata;
        REG_DURATION: dur_r <= cfg_pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_POINT0:   cfg_prdata = point_r[0];
      REG_POINT1:   cfg_prdata = point_r[1];
      REG_POINT2:   cfg_prdata = point_r[2];
      REG_POINT3:   cfg_prdata = point_r[3];
      REG_POINT4:   cfg_prdata = point_r[4];
      REG_POINT5:   cfg_prdata = point_r[5];
      REG_DURATION: cfg_prdata = {16'd0, dur_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // power-basis coefficients from control points
  always_ff @(posedge clk) begin
    logic signed [COEF_W-1:0] p [6];
    for (int i = 0; i < 6; i++) p[i] = COEF_W'(point_r[i]);
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
    end else begin
      coef_r[5] <= -p[0] + 5 * p[1] - 10 * p[2] + 10 * p[3] - 5 * p[4] + p[5];
      coef_r[4] <= 5 * p[0] - 20 * p[1] + 30 * p[2] - 20 * p[3] + 5 * p[4];
      coef_r[3] <= -10 * p[0] + 30 * p[1] - 30 * p[2] + 10 * p[3];
      coef_r[2] <= 10 * p[0] - 20 * p[1] + 10 * p[2];
      coef_r[1] <= -5 * p[0] + 5 * p[1];
      coef_r[0] <= p[0];
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) b[i] = ACC_W'(coef_r[i]);
  end

  // addend for each horner step: position, then velocity, then acceleration
  always_comb begin
    case (m_r)
      4'd0:    addend = b[4];
      4'd1:    addend = b[3];
      4'd2:    addend = b[2];
      4'd3:    addend = b[1];
      4'd4:    addend = b[0];
      4'd5:    addend = 4 * b[4];
      4'd6:    addend = 3 * b[3];
      4'd7:    addend = 2 * b[2];
      4'd8:    addend = b[1];
      4'd9:    addend = 12 * b[4];
      4'd10:   addend = 6 * b[3];
      4'd11:   addend = 2 * b[2];
      default: addend = '0;
    endcase
  end

  // floor of product over 2^frac plus addend
  assign horner = prod_r[T_FRAC_BITS +: ACC_W] + addend;

  // shared divider: normalized time, then velocity over duration
  assign div_start    = (st_r == S_IDLE && in_acc && in_tdata[1:0] == FUNC_EVAL && !finished)
                      || (st_r == S_ADD && m_r == 4'd11);
  assign d_fin        = back_r ? -vel_r : vel_r;
  assign div_dividend = (st_r == S_IDLE)
                      ? (DIV_W'(elapsed_r) << T_FRAC_BITS)
                      : DIV_W'(d_fin[ACC_W-1] ? -d_fin : d_fin);
  assign t_div        = div_quo[T_W-1:0];

  qbt_div #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dur_eff),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      elapsed_r   <= EL_W'(1) << TIME_BITS;
      out_valid_r <= 1'b0;
      m_r         <= '0;
      mcnt_r      <= '0;
    end else begin
      // output register drains here unless a new result is loaded below
      if (out_valid_r && out_tready && st_r != S_FIN) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            pos_r  <= '0;
            vel_r  <= '0;
            acc_r  <= '0;
            back_r <= in_tuser;
            m_r    <= '0;
            h_r    <= b[5];
            case (in_tdata[1:0])
              FUNC_TICK: begin
                if (!finished) elapsed_r <= elapsed_r + 1'b1;
                st_r <= S_FIN;
              end
              FUNC_START: begin
                if (finished) elapsed_r <= '0;
                st_r <= S_FIN;
              end
              FUNC_EVAL: begin
                if (finished) begin
                  t_r  <= in_tuser ? '0 : T_ONE;
                  st_r <= S_LOAD;
                end else begin
                  st_r <= S_TDIV;
                end
              end
              default: st_r <= S_FIN;
            endcase
          end
        end
        S_TDIV: begin
          if (div_stat.done) begin
            t_r  <= back_r ? T_ONE - t_div : t_div;
            st_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          prod_r  <= '0;
          mcand_r <= PW'(h_r);
          tsh_r   <= t_r;
          mcnt_r  <= '0;
          st_r    <= S_MUL;
        end
        S_MUL: begin
          // one partial product per cycle, lsb of t first
          if (tsh_r[0]) prod_r <= prod_r + mcand_r;
          mcand_r <= mcand_r <<< 1;
          tsh_r   <= tsh_r >> 1;
          mcnt_r  <= mcnt_r + 1'b1;
          if (mcnt_r == MC_W'(T_W - 1)) st_r <= S_ADD;
        end
        S_ADD: begin
          m_r <= m_r + 1'b1;
          case (m_r)
            4'd4: begin
              pos_r <= horner;
              h_r   <= 5 * b[5];
              st_r  <= S_LOAD;
            end
            4'd8: begin
              vel_r <= horner;
              h_r   <= 20 * b[5];
              st_r  <= S_LOAD;
            end
            4'd11: begin
              acc_r  <= horner;
              vneg_r <= d_fin[ACC_W-1];
              st_r   <= S_VDIV;
            end
            default: begin
              h_r  <= horner;
              st_r <= S_LOAD;
            end
          endcase
        end
        S_VDIV: begin
          if (div_stat.done) begin
            vel_r <= vneg_r ? -ACC_W'(div_quo) : ACC_W'(div_quo);
            st_r  <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {sat32(acc_r), sat32(vel_r), sat32(pos_r)};
            out_fin_r   <= finished;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fin_r;

`ifndef NO_ASSERTIONS
  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (st_r == S_TDIV || st_r == S_VDIV))
    else $error("divider done outside a divide state");

  // normalized time never exceeds one during multiplication
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MUL) |-> (t_r <= T_ONE))
    else $error("normalized time out of range");

  // a result is loaded only when the output register is free or draining
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && st_r == S_FIN) |=> (st_r == S_FIN))
    else $error("result overwritten before it was taken");
`endif

endmodule
